FILE: src/jsdu_pkg.sv
// Shared types and constants for the joint space distance unit.
// No dependencies.
package jsdu_pkg;

   localparam int JOINTS     = 5;
   localparam int ANGLE_W    = 16;
   localparam int MAG_W      = 16;
   localparam int SQ_W       = 32;
   localparam int RAD_W      = 36;
   localparam int ROOT_W     = 18;
   localparam int SQ_REM_W   = 22;
   localparam int VEL_W      = 15;
   localparam int DIST_W     = 24;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [VEL_W-1:0]  VEL_RESET = 15'd4096;
   localparam logic [DIST_W-1:0] DIST_MAX  = 24'hFFFFFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_EUCLID   = 2'd0,
      MODE_CHESS    = 2'd1,
      MODE_DURATION = 2'd2,
      MODE_UNUSED   = 2'd3
   } metric_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_METRIC_MODE = 3'd0,
      CSR_VEL_ONE     = 3'd1,
      CSR_VEL_TWO     = 3'd2,
      CSR_VEL_THREE   = 3'd3,
      CSR_VEL_FOUR    = 3'd4,
      CSR_VEL_FIVE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] first_angle_one;
      logic signed [ANGLE_W-1:0] first_angle_two;
      logic signed [ANGLE_W-1:0] first_angle_three;
      logic signed [ANGLE_W-1:0] first_angle_four;
      logic signed [ANGLE_W-1:0] first_angle_five;
      logic signed [ANGLE_W-1:0] second_angle_one;
      logic signed [ANGLE_W-1:0] second_angle_two;
      logic signed [ANGLE_W-1:0] second_angle_three;
      logic signed [ANGLE_W-1:0] second_angle_four;
      logic signed [ANGLE_W-1:0] second_angle_five;
   } req_payload_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance_value;
      logic              saturated;
   } rsp_payload_type;

   typedef logic [JOINTS-1:0][MAG_W-1:0] mag_vec_type;
   typedef logic [JOINTS-1:0][VEL_W-1:0] vel_vec_type;

   typedef struct packed {
      mag_vec_type      mag;
      logic [RAD_W-1:0] sum_sq;
      logic [MAG_W-1:0] mag_max;
   } front_data_type;

endpackage

FILE: src/joint_space_distance_unit_top.sv
// Joint space distance unit: takes one pair of 5-joint poses per cycle while
// req_stall is low and returns one distance per pose pair, Q12.12 in duration
// mode and an integer otherwise. The depth is set by the restoring dividers of
// duration mode, which resolve one quotient bit per stage. Square root and
// dividers run side by side, so every mode has the same latency. An output
// register and a skid stage let the block take a new beat while a result waits.
// Depends on jsdu_pkg, jsdu_front, jsdu_iter and jsdu_back.
module joint_space_distance_unit_top
   import jsdu_pkg::*;
#(
   parameter int FRACTION_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QW = MAG_W + FRACTION_BITS;

   logic [MODE_W-1:0] mode_ff, mode_in;
   vel_vec_type       vel_ff, vel_in;

   always_comb begin
      mode_in = mode_ff;
      vel_in  = vel_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_METRIC_MODE: mode_in   = csr_wdata[MODE_W-1:0];
            CSR_VEL_ONE:     vel_in[0] = csr_wdata[VEL_W-1:0];
            CSR_VEL_TWO:     vel_in[1] = csr_wdata[VEL_W-1:0];
            CSR_VEL_THREE:   vel_in[2] = csr_wdata[VEL_W-1:0];
            CSR_VEL_FOUR:    vel_in[3] = csr_wdata[VEL_W-1:0];
            CSR_VEL_FIVE:    vel_in[4] = csr_wdata[VEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_EUCLID;
         vel_ff  <= {JOINTS{VEL_RESET}};
      end else begin
         mode_ff <= mode_in;
         vel_ff  <= vel_in;
      end
   end

   logic                      adv;
   logic                      front_valid;
   front_data_type            front_data;
   logic                      iter_valid;
   logic [ROOT_W-1:0]         iter_root;
   logic [MAG_W-1:0]          iter_mag_max;
   logic [JOINTS-1:0][QW-1:0] iter_quo;

   assign req_stall = !adv;

   jsdu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .front_valid (front_valid),
      .front_data  (front_data)
   );

   jsdu_iter #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_iter (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .front_valid  (front_valid),
      .front_data   (front_data),
      .vel          (vel_ff),
      .iter_valid   (iter_valid),
      .iter_root    (iter_root),
      .iter_mag_max (iter_mag_max),
      .iter_quo     (iter_quo)
   );

   jsdu_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .iter_valid   (iter_valid),
      .iter_root    (iter_root),
      .iter_mag_max (iter_mag_max),
      .iter_quo     (iter_quo),
      .vel          (vel_ff),
      .mode         (mode_ff),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .adv          (adv)
   );

endmodule

FILE: src/jsdu_front.sv
// Front stages: joint differences, squares, sum of squares and largest difference.
// Depends on jsdu_pkg.
module jsdu_front
   import jsdu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            req_valid,
   input  req_payload_type req_payload,
   output logic            front_valid,
   output front_data_type  front_data
);

   logic signed [ANGLE_W-1:0] first_ang [JOINTS];
   logic signed [ANGLE_W-1:0] second_ang [JOINTS];

   assign first_ang[0]  = req_payload.first_angle_one;
   assign first_ang[1]  = req_payload.first_angle_two;
   assign first_ang[2]  = req_payload.first_angle_three;
   assign first_ang[3]  = req_payload.first_angle_four;
   assign first_ang[4]  = req_payload.first_angle_five;
   assign second_ang[0] = req_payload.second_angle_one;
   assign second_ang[1] = req_payload.second_angle_two;
   assign second_ang[2] = req_payload.second_angle_three;
   assign second_ang[3] = req_payload.second_angle_four;
   assign second_ang[4] = req_payload.second_angle_five;

   mag_vec_type                     mag_in, mag_a_ff, mag_b_ff;
   logic [JOINTS-1:0][SQ_W-1:0]     sq_in, sq_ff;
   logic                            va_ff, vb_ff, vc_ff;
   logic [RAD_W-1:0]                sum_in;
   logic [MAG_W-1:0]                max_in;
   front_data_type                  data_ff;

   always_comb begin
      logic signed [ANGLE_W:0] d;
      mag_in = '0;
      for (int j = 0; j < JOINTS; j++) begin
         d = {first_ang[j][ANGLE_W-1], first_ang[j]} - {second_ang[j][ANGLE_W-1], second_ang[j]};
         mag_in[j] = d[ANGLE_W] ? MAG_W'(-d) : MAG_W'(d);
      end
   end

   always_comb begin
      for (int j = 0; j < JOINTS; j++) begin
         sq_in[j] = SQ_W'(mag_a_ff[j]) * SQ_W'(mag_a_ff[j]);
      end
   end

   always_comb begin
      sum_in = '0;
      max_in = '0;
      for (int j = 0; j < JOINTS; j++) begin
         sum_in = sum_in + RAD_W'(sq_ff[j]);
         if (mag_b_ff[j] > max_in) begin
            max_in = mag_b_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_a_ff        <= mag_in;
         mag_b_ff        <= mag_a_ff;
         sq_ff           <= sq_in;
         data_ff.mag     <= mag_b_ff;
         data_ff.sum_sq  <= sum_in;
         data_ff.mag_max <= max_in;
      end
   end

   assign front_valid = vc_ff;
   assign front_data  = data_ff;

endmodule

FILE: src/jsdu_iter.sv
// Bit-per-stage pipeline: five restoring dividers and one integer square root.
// Depends on jsdu_pkg.
module jsdu_iter
   import jsdu_pkg::*;
#(
   parameter int FRACTION_BITS = 12
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       adv,
   input  logic                                       front_valid,
   input  front_data_type                             front_data,
   input  vel_vec_type                                vel,
   output logic                                       iter_valid,
   output logic [ROOT_W-1:0]                          iter_root,
   output logic [MAG_W-1:0]                           iter_mag_max,
   output logic [JOINTS-1:0][MAG_W+FRACTION_BITS-1:0] iter_quo
);

   localparam int QW    = MAG_W + FRACTION_BITS;
   localparam int STEPS = QW;

   logic                         v_ff    [STEPS];
   logic [JOINTS-1:0][QW-1:0]    dvd_ff  [STEPS];
   logic [JOINTS-1:0][QW-1:0]    quo_ff  [STEPS];
   logic [JOINTS-1:0][VEL_W-1:0] drem_ff [STEPS];
   logic [RAD_W-1:0]             rad_ff  [STEPS];
   logic [SQ_REM_W-1:0]          srem_ff [STEPS];
   logic [ROOT_W-1:0]            root_ff [STEPS];
   logic [MAG_W-1:0]             mmax_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic                         v_cur;
      logic [JOINTS-1:0][QW-1:0]    dvd_cur, quo_cur, dvd_in, quo_in;
      logic [JOINTS-1:0][VEL_W-1:0] drem_cur, drem_in;
      logic [RAD_W-1:0]             rad_cur, rad_in;
      logic [SQ_REM_W-1:0]          srem_cur, srem_in;
      logic [ROOT_W-1:0]            root_cur, root_in;
      logic [MAG_W-1:0]             mmax_cur;

      if (k == 0) begin : g_first
         assign v_cur    = front_valid;
         assign quo_cur  = '0;
         assign drem_cur = '0;
         assign rad_cur  = front_data.sum_sq;
         assign srem_cur = '0;
         assign root_cur = '0;
         assign mmax_cur = front_data.mag_max;
         for (genvar j = 0; j < JOINTS; j++) begin : g_dvd
            assign dvd_cur[j] = {front_data.mag[j], {FRACTION_BITS{1'b0}}};
         end
      end else begin : g_next
         assign v_cur    = v_ff[k-1];
         assign dvd_cur  = dvd_ff[k-1];
         assign quo_cur  = quo_ff[k-1];
         assign drem_cur = drem_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
         assign srem_cur = srem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign mmax_cur = mmax_ff[k-1];
      end

      always_comb begin
         logic [VEL_W:0] r;
         logic           ge;
         for (int j = 0; j < JOINTS; j++) begin
            r          = {drem_cur[j], dvd_cur[j][QW-1]};
            ge         = (r >= {1'b0, vel[j]});
            drem_in[j] = ge ? VEL_W'(r - {1'b0, vel[j]}) : VEL_W'(r);
            quo_in[j]  = {quo_cur[j][QW-2:0], ge};
            dvd_in[j]  = {dvd_cur[j][QW-2:0], 1'b0};
         end
      end

      if (k < ROOT_W) begin : g_sqrt
         always_comb begin
            logic [SQ_REM_W-1:0] t;
            logic [SQ_REM_W-1:0] trial;
            t     = {srem_cur[SQ_REM_W-3:0], rad_cur[RAD_W-1 -: 2]};
            trial = SQ_REM_W'({root_cur, 2'b01});
            if (t >= trial) begin
               srem_in = t - trial;
               root_in = {root_cur[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = t;
               root_in = {root_cur[ROOT_W-2:0], 1'b0};
            end
            rad_in = {rad_cur[RAD_W-3:0], 2'b00};
         end
      end else begin : g_hold
         assign srem_in = srem_cur;
         assign root_in = root_cur;
         assign rad_in  = rad_cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dvd_ff[k]  <= dvd_in;
            quo_ff[k]  <= quo_in;
            drem_ff[k] <= drem_in;
            rad_ff[k]  <= rad_in;
            srem_ff[k] <= srem_in;
            root_ff[k] <= root_in;
            mmax_ff[k] <= mmax_cur;
         end
      end
   end

   assign iter_valid   = v_ff[STEPS-1];
   assign iter_root    = root_ff[STEPS-1];
   assign iter_mag_max = mmax_ff[STEPS-1];
   assign iter_quo     = quo_ff[STEPS-1];

endmodule

FILE: src/jsdu_back.sv
// Metric select, saturation and output register with skid stage.
// Depends on jsdu_pkg.
module jsdu_back
   import jsdu_pkg::*;
#(
   parameter int FRACTION_BITS = 12
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       iter_valid,
   input  logic [ROOT_W-1:0]                          iter_root,
   input  logic [MAG_W-1:0]                           iter_mag_max,
   input  logic [JOINTS-1:0][MAG_W+FRACTION_BITS-1:0] iter_quo,
   input  vel_vec_type                                vel,
   input  logic [MODE_W-1:0]                          mode,
   input  logic                                       rsp_stall,
   output logic                                       rsp_valid,
   output rsp_payload_type                            rsp_payload,
   output logic                                       adv
);

   localparam int QW = MAG_W + FRACTION_BITS;

   rsp_payload_type res_in, res_ff, out_in, out_ff, skid_in, skid_ff;
   logic            res_valid_ff, out_valid_in, out_valid_ff, skid_valid_in, skid_valid_ff;

   always_comb begin
      logic [QW-1:0] qmax;
      logic          vel_zero;
      qmax     = '0;
      vel_zero = 1'b0;
      for (int j = 0; j < JOINTS; j++) begin
         if (iter_quo[j] > qmax) begin
            qmax = iter_quo[j];
         end
         if (vel[j] == '0) begin
            vel_zero = 1'b1;
         end
      end
      res_in = '0;
      unique case (metric_mode_type'(mode))
         MODE_EUCLID: begin
            res_in.distance_value = DIST_W'(iter_root);
         end
         MODE_CHESS: begin
            res_in.distance_value = DIST_W'(iter_mag_max);
         end
         MODE_DURATION: begin
            if (vel_zero || qmax > QW'(DIST_MAX)) begin
               res_in.distance_value = DIST_MAX;
               res_in.saturated      = 1'b1;
            end else begin
               res_in.distance_value = qmax[DIST_W-1:0];
            end
         end
         MODE_UNUSED: begin
            res_in = '0;
         end
      endcase
   end

   assign adv = !skid_valid_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && !rsp_stall) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (adv && res_valid_ff) begin
         if (!out_valid_ff || !rsp_stall) begin
            out_in       = res_ff;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res_ff;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            res_valid_ff <= iter_valid;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
